/* design/assert_macros.svh */
// Assertion macros used by the top-level design file.
// No dependencies; the assertion forms are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HPD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HPD_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define HPD_ASSERT(label, clk, rstn, prop, msg)
`define HPD_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

/* design/hpd_pkg.sv */
// Package for the HPACK Huffman decoder: payload types, codes and the canonical code tables.
// No dependencies.
package hpd_pkg;

    localparam int NUM_CODES          = 257;
    localparam int MIN_LEN            = 5;
    localparam int MAX_LEN            = 30;
    localparam int BUF_W              = 37;
    localparam int PEND_W             = 29;
    localparam int PAD_MAX            = 7;
    localparam int RANK_W             = 9;
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int CAP_W              = 16;
    localparam int CFG_IDX_W          = 8;
    localparam int CFG_DATA_W         = 16;
    localparam logic [RANK_W-1:0] EOS_RANK  = 9'd256;
    localparam logic [CAP_W-1:0]  CAP_RESET = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CAP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EOS_TERM   = 8'd1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_PAD  = 2'd1;
    localparam logic [1:0] ST_EOS      = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       symbol_valid;
        logic       string_done;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    typedef logic [4:0]  len_rom_t  [0:NUM_CODES-1];
    typedef logic [31:0] len_tab_t  [0:MAX_LEN];
    typedef logic [7:0]  rank_tab_t [0:NUM_CODES-1];

    localparam len_rom_t CODE_LEN = '{
        13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
        28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
        6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
        5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
        13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
        7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
        15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
        6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
        20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
        24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
        22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
        21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
        26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
        19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
        20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
        26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26,
        30
    };

    // Number of codes of each length.
    function automatic len_tab_t calc_count();
        len_tab_t t;
        for (int l = 0; l <= MAX_LEN; l++) begin
            t[l] = '0;
        end
        for (int s = 0; s < NUM_CODES; s++) begin
            t[CODE_LEN[s]] = t[CODE_LEN[s]] + 32'd1;
        end
        return t;
    endfunction

    // First canonical code value of each length.
    function automatic len_tab_t calc_first();
        len_tab_t c;
        len_tab_t t;
        logic [31:0] nxt;
        c   = calc_count();
        nxt = '0;
        t[0] = '0;
        for (int l = 1; l <= MAX_LEN; l++) begin
            t[l] = nxt;
            nxt  = (nxt + c[l]) << 1;
        end
        return t;
    endfunction

    // Rank of the first code of each length in length-then-symbol order.
    function automatic len_tab_t calc_base();
        len_tab_t c;
        len_tab_t t;
        logic [31:0] acc;
        c   = calc_count();
        acc = '0;
        for (int l = 0; l <= MAX_LEN; l++) begin
            t[l] = acc;
            acc  = acc + c[l];
        end
        return t;
    endfunction

    // Decoded octet for each rank; the end-of-string code sits at the last rank.
    function automatic rank_tab_t calc_sym();
        rank_tab_t t;
        int r;
        r = 0;
        for (int l = 1; l <= MAX_LEN; l++) begin
            for (int s = 0; s < NUM_CODES; s++) begin
                if (int'(CODE_LEN[s]) == l) begin
                    t[r] = 8'(s);
                    r = r + 1;
                end
            end
        end
        return t;
    endfunction

    localparam len_tab_t  LEN_COUNT   = calc_count();
    localparam len_tab_t  LEN_FIRST   = calc_first();
    localparam len_tab_t  LEN_BASE    = calc_base();
    localparam rank_tab_t SYM_BY_RANK = calc_sym();

endpackage

/* design/hpack_huffman_decoder_top.sv */
// Top level of the HPACK Huffman string decoder.
// Depends on hpd_pkg and assert_macros.svh.
//
// The decoder takes the coded bytes of one HPACK string, one byte per input transaction, and
// returns a decoded octet per result transaction, followed after the byte flagged last_byte by
// a closing result that carries the string's status. A byte is accepted only when the decoder
// is idle; it then appends the byte to the bit buffer, matches the codes it holds one at a time
// (at most two per byte) and finishes the byte, and builds each result by a synchronous read
// of the rank-to-octet table followed by a load of the output register. The output register
// lets the last result wait for the consumer while the next byte is taken. Codes are recognised
// by comparing the top of the buffer against the first canonical code of every length at once;
// the shortest length that hits gives the code's rank. Errors are sticky for the rest of the
// string, and a complete EOS code either ends the string successfully or is reported as an
// error, as selected by the eos_term_reg register. Configuration writes are always accepted
// and take effect in the following cycle.
`include "assert_macros.svh"

module hpack_huffman_decoder_top #(
    parameter int COUNT_BITS = hpd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  hpd_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output hpd_pkg::out_item_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int BW  = hpd_pkg::BUF_W;
    localparam int CMP = COUNT_BITS + hpd_pkg::CAP_W + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MATCH = 4'b0010,
        S_RD    = 4'b0100,
        S_WR    = 4'b1000
    } state_t;

    state_t                           state_reg, state_next;
    logic [BW-1:0]                    buf_reg, buf_next;
    logic [5:0]                       cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]            sym_count_reg, sym_count_next;
    logic [1:0]                       err_reg, err_next;
    logic                             eos_reg, eos_next;
    logic                             lastb_reg, lastb_next;
    logic [1:0]                       nsym_reg, nsym_next;
    logic [1:0]                       idx_reg, idx_next;
    logic [hpd_pkg::RANK_W-1:0]       rank_reg [0:1];
    logic [hpd_pkg::RANK_W-1:0]       rank_next [0:1];
    logic [hpd_pkg::CAP_W-1:0]        cap_reg, cap_next;
    logic                             eos_term_reg, eos_term_next;
    logic                             out_valid_reg, out_valid_next;
    hpd_pkg::out_item_t               out_data_reg, out_data_next;
    logic [7:0]                       rom_q_reg;

    logic                             hit;
    logic [4:0]                       hit_len;
    logic [hpd_pkg::RANK_W-1:0]       hit_rank;
    logic [BW-1:0]                    win;
    logic [BW-1:0]                    v;
    logic [5:0]                       rem;
    logic                             cap_fail;
    logic                             out_free;
    logic                             close_load;
    logic [1:0]                       pad_status;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Parallel match of the buffer head against every code length; shortest hit wins.
    always_comb
    begin
        win      = buf_reg << (6'(BW) - cnt_reg);
        hit      = 1'b0;
        hit_len  = '0;
        hit_rank = '0;
        v        = '0;
        for (int l = hpd_pkg::MAX_LEN; l >= hpd_pkg::MIN_LEN; l--)
        begin
            v = win >> (BW - l);
            if ((32'(cnt_reg) >= 32'(l)) && (hpd_pkg::LEN_COUNT[l] != 32'd0) &&
                (v >= BW'(hpd_pkg::LEN_FIRST[l])) &&
                (v < BW'(hpd_pkg::LEN_FIRST[l] + hpd_pkg::LEN_COUNT[l])))
            begin
                hit      = 1'b1;
                hit_len  = 5'(l);
                hit_rank = hpd_pkg::RANK_W'(hpd_pkg::LEN_BASE[l] +
                           32'(v) - hpd_pkg::LEN_FIRST[l]);
            end
        end
    end

    assign rem      = cnt_reg - {1'b0, hit_len};
    assign cap_fail = (CMP'(sym_count_reg) >= CMP'(cap_reg)) || (&sym_count_reg);

    // Closing status: first error; after EOS OK; else padding must be short and all ones.
    always_comb
    begin
        if (err_reg != hpd_pkg::ST_OK)
        begin
            pad_status = err_reg;
        end
        else if (eos_reg)
        begin
            pad_status = hpd_pkg::ST_OK;
        end
        else if ((cnt_reg > 6'(hpd_pkg::PAD_MAX)) || (buf_reg != ~({BW{1'b1}} << cnt_reg)))
        begin
            pad_status = hpd_pkg::ST_BAD_PAD;
        end
        else
        begin
            pad_status = hpd_pkg::ST_OK;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        sym_count_next = sym_count_reg;
        err_next       = err_reg;
        eos_next       = eos_reg;
        lastb_next     = lastb_reg;
        nsym_next      = nsym_reg;
        idx_next       = idx_reg;
        rank_next[0]   = rank_reg[0];
        rank_next[1]   = rank_reg[1];
        cap_next       = cap_reg;
        eos_term_next  = eos_term_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        close_load     = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                hpd_pkg::CFG_OUTPUT_CAP: cap_next      = cfg_data[hpd_pkg::CAP_W-1:0];
                hpd_pkg::CFG_EOS_TERM:   eos_term_next = cfg_data[0];
                default:                 ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    lastb_next = in_data.last_byte;
                    nsym_next  = '0;
                    idx_next   = '0;
                    if ((err_reg == hpd_pkg::ST_OK) && !eos_reg)
                    begin
                        buf_next = {buf_reg[hpd_pkg::PEND_W-1:0], in_data.data_byte};
                        cnt_next = cnt_reg + 6'd8;
                    end
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                if ((err_reg == hpd_pkg::ST_OK) && !eos_reg && (nsym_reg != 2'd2) && hit)
                begin
                    buf_next = buf_reg & ~({BW{1'b1}} << rem);
                    cnt_next = rem;
                    if (hit_rank == hpd_pkg::EOS_RANK)
                    begin
                        if (eos_term_reg)
                        begin
                            eos_next = 1'b1;
                            buf_next = '0;
                            cnt_next = '0;
                        end
                        else
                        begin
                            err_next = hpd_pkg::ST_EOS;
                        end
                    end
                    else if (cap_fail)
                    begin
                        err_next = hpd_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        rank_next[nsym_reg[0]] = hit_rank;
                        nsym_next      = nsym_reg + 2'd1;
                        sym_count_next = sym_count_reg + COUNT_BITS'(1);
                    end
                end
                else
                begin
                    if (cnt_reg > 6'(hpd_pkg::PEND_W))
                    begin
                        cnt_next = 6'(hpd_pkg::PEND_W);
                        buf_next = buf_reg & ~({BW{1'b1}} << hpd_pkg::PEND_W);
                    end
                    if ((nsym_reg == 2'd0) && !lastb_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (idx_reg == nsym_reg)
                    begin
                        close_load                 = 1'b1;
                        out_data_next.symbol       = '0;
                        out_data_next.symbol_valid = 1'b0;
                        out_data_next.string_done  = 1'b1;
                        out_data_next.status       = pad_status;
                        out_data_next.last         = 1'b1;
                        buf_next       = '0;
                        cnt_next       = '0;
                        sym_count_next = '0;
                        err_next       = hpd_pkg::ST_OK;
                        eos_next       = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        out_data_next.symbol       = rom_q_reg;
                        out_data_next.symbol_valid = 1'b1;
                        out_data_next.string_done  = 1'b0;
                        out_data_next.status       = hpd_pkg::ST_OK;
                        out_data_next.last = ((idx_reg + 2'd1) == nsym_reg) && !lastb_reg;
                        if (((idx_reg + 2'd1) == nsym_reg) && !lastb_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    idx_next = idx_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Rank-to-octet table, read synchronously at the rank of the result being built.
    always_ff @(posedge clk)
    begin
        rom_q_reg <= hpd_pkg::SYM_BY_RANK[rank_reg[idx_reg[0]]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            buf_reg       <= '0;
            cnt_reg       <= '0;
            sym_count_reg <= '0;
            err_reg       <= hpd_pkg::ST_OK;
            eos_reg       <= 1'b0;
            lastb_reg     <= 1'b0;
            nsym_reg      <= '0;
            idx_reg       <= '0;
            cap_reg       <= hpd_pkg::CAP_RESET;
            eos_term_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            sym_count_reg <= sym_count_next;
            err_reg       <= err_next;
            eos_reg       <= eos_next;
            lastb_reg     <= lastb_next;
            nsym_reg      <= nsym_next;
            idx_reg       <= idx_next;
            cap_reg       <= cap_next;
            eos_term_reg  <= eos_term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg[0]  <= rank_next[0];
        rank_reg[1]  <= rank_next[1];
        out_data_reg <= out_data_next;
    end

    `HPD_NEVER(a_cnt_range, clk, rst_n, cnt_reg > 6'(BW), "bit buffer count out of range")
    `HPD_ASSERT(a_accept_match, clk, rst_n, (in_valid && in_ready) |=> (state_reg == S_MATCH), "accepted byte not matched")
    `HPD_ASSERT(a_close_clear, clk, rst_n, close_load |=> ((sym_count_reg == '0) && (err_reg == hpd_pkg::ST_OK)), "string state not cleared after close")
    `HPD_NEVER(a_nsym_idx, clk, rst_n, (state_reg == S_WR) && (idx_reg > nsym_reg), "result index past symbol count")

endmodule
